// ----- hw/rtl/mp2d_pkg.sv -----
// Shared types and constants for the streaming 2-D max pooling block.
// No dependencies; used by mp2d_seq, mp2d_rmw and max_pool_2d_stream.
`default_nettype none

package mp2d_pkg;

   // Pixel and register widths fixed by the interface, height bound and reset dimension
   localparam int PIXEL_W      = 16;
   localparam int DIM_W        = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int RESET_DIM    = 256;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Control bits that travel with one read-modify-write operation
   typedef struct packed {
      logic first;          // first pixel of the window: overwrite, read value ignored
      logic emit;           // window completes here and a result is reported
      logic end_of_row;
      logic end_of_frame;
      logic end_of_run;
   } op_flags_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mp2d_seq.sv -----
// Position tracking and window sequencer: walks the windows that cover each pixel.
// Depends on mp2d_pkg; issues one memory operation per covering window.
`default_nettype none

module mp2d_seq #(
   parameter int POOL_SIZE = 2,
   parameter int STRIDE    = 2,
   parameter int COLS      = 512,
   parameter int RS        = 1,
   parameter int WW        = 11,
   parameter int JW        = 9,
   parameter int SLW       = 1,
   parameter int AW        = 9
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               restart,
   input  wire logic [WW-1:0]                      img_w,
   input  wire logic [mp2d_pkg::DIM_W-1:0]         img_h,
   input  wire logic                               req_valid,
   input  wire logic signed [mp2d_pkg::PIXEL_W-1:0] req_pixel,
   output logic                                    req_stall,
   input  wire logic                               issue_ok,
   output logic                                    op_valid,
   output logic [AW-1:0]                           op_addr,
   output logic signed [mp2d_pkg::PIXEL_W-1:0]     op_pixel,
   output mp2d_pkg::op_flags_type                  op_flags
);

   localparam int HW = mp2d_pkg::DIM_W;
   localparam int EW = WW + 4;
   localparam int EH = HW + 4;
   localparam logic [EW-1:0] C_PM1  = EW'(POOL_SIZE - 1);
   localparam logic [EW-1:0] C_STEP = EW'(STRIDE);
   localparam logic [EH-1:0] R_PM1  = EH'(POOL_SIZE - 1);
   localparam logic [EH-1:0] R_STEP = EH'(STRIDE);
   localparam logic [SLW-1:0] SLOT_LAST = SLW'(RS - 1);

   // Position of the next pixel and first covering window in each direction
   logic [WW-1:0]  col_ff, col_in;
   logic [JW-1:0]  jf_ff, jf_in;
   logic [EW-1:0]  jfs_ff, jfs_in;
   logic [HW-1:0]  row_ff, row_in;
   logic [EH-1:0]  kfs_ff, kfs_in;
   logic [SLW-1:0] kfslot_ff, kfslot_in;

   // Pixel under work and its window iterator
   logic                                cur_valid_ff, cur_valid_in;
   logic signed [mp2d_pkg::PIXEL_W-1:0] pix_ff, pix_in;
   logic [HW-1:0]  cr_ff, cr_in;
   logic [WW-1:0]  cc_ff, cc_in;
   logic           r_last_ff, r_last_in;
   logic           c_last_ff, c_last_in;
   logic           multi_ff, multi_in;
   logic [JW-1:0]  jf_c_ff, jf_c_in;
   logic [EW-1:0]  jfs_c_ff, jfs_c_in;
   logic [JW-1:0]  j_ff, j_in;
   logic [EW-1:0]  js_ff, js_in;
   logic [EH-1:0]  ks_ff, ks_in;
   logic [SLW-1:0] slot_ff, slot_in;
   logic [1:0]     n_ff, n_in;

   logic [EW-1:0] col_e, cc_e, w_e;
   logic [EH-1:0] row_e, cr_e, h_e;
   logic pos_in_window, c_last_pos, r_last_pos, multi_pos;
   logic row_last, col_last, emit, last_j, last_k, last_op;
   logic fire, done, accept;

   assign col_e = EW'(col_ff);
   assign cc_e  = EW'(cc_ff);
   assign w_e   = EW'(img_w);
   assign row_e = EH'(row_ff);
   assign cr_e  = EH'(cr_ff);
   assign h_e   = EH'(img_h);

   // Classify the next pixel
   assign pos_in_window = (kfs_ff <= row_e) && (jfs_ff <= col_e);
   assign c_last_pos    = (col_e + EW'(1)) == w_e;
   assign r_last_pos    = (row_e + EH'(1)) == h_e;
   assign multi_pos     = (c_last_pos && ((jfs_ff + C_STEP) <= col_e)) ||
                          (r_last_pos && ((kfs_ff + R_STEP) <= row_e));

   // Decode the current window of the current pixel
   assign row_last = r_last_ff || ((ks_ff + R_PM1) == cr_e);
   assign col_last = c_last_ff || ((js_ff + C_PM1) == cc_e);
   assign emit     = row_last && col_last && !n_ff[1];
   assign last_j   = (js_ff + C_STEP) > cc_e;
   assign last_k   = (ks_ff + R_STEP) > cr_e;
   assign last_op  = last_j && last_k;

   assign fire      = cur_valid_ff && issue_ok;
   assign done      = fire && last_op;
   assign req_stall = cur_valid_ff && !done;
   assign accept    = req_valid && !req_stall;

   assign op_valid = cur_valid_ff;
   assign op_pixel = pix_ff;
   assign op_addr  = AW'(AW'(slot_ff) * AW'(COLS) + AW'(j_ff));

   always_comb begin
      op_flags.first        = (ks_ff == EH'(cr_ff)) && (js_ff == EW'(cc_ff));
      op_flags.emit         = emit;
      op_flags.end_of_row   = (js_ff + C_STEP) >= w_e;
      op_flags.end_of_frame = ((js_ff + C_STEP) >= w_e) && ((ks_ff + R_STEP) >= h_e);
      op_flags.end_of_run   = emit && ((n_ff == 2'd1) || !multi_ff);
   end

   // Next-state logic
   always_comb begin
      col_in       = col_ff;
      jf_in        = jf_ff;
      jfs_in       = jfs_ff;
      row_in       = row_ff;
      kfs_in       = kfs_ff;
      kfslot_in    = kfslot_ff;
      cur_valid_in = cur_valid_ff;
      pix_in       = pix_ff;
      cr_in        = cr_ff;
      cc_in        = cc_ff;
      r_last_in    = r_last_ff;
      c_last_in    = c_last_ff;
      multi_in     = multi_ff;
      jf_c_in      = jf_c_ff;
      jfs_c_in     = jfs_c_ff;
      j_in         = j_ff;
      js_in        = js_ff;
      ks_in        = ks_ff;
      slot_in      = slot_ff;
      n_in         = n_ff;

      // Step to the next covering window
      if (fire && !last_op) begin
         n_in = n_ff + {1'b0, emit};
         if (last_j) begin
            j_in    = jf_c_ff;
            js_in   = jfs_c_ff;
            ks_in   = ks_ff + R_STEP;
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLW'(1);
         end else begin
            j_in  = j_ff + JW'(1);
            js_in = js_ff + C_STEP;
         end
      end

      if (done) begin
         cur_valid_in = 1'b0;
      end

      // Take a new item: load the iterator if it lies in a window, advance the position
      if (accept) begin
         if (pos_in_window) begin
            cur_valid_in = 1'b1;
            pix_in       = req_pixel;
            cr_in        = row_ff;
            cc_in        = col_ff;
            r_last_in    = r_last_pos;
            c_last_in    = c_last_pos;
            multi_in     = multi_pos;
            jf_c_in      = jf_ff;
            jfs_c_in     = jfs_ff;
            j_in         = jf_ff;
            js_in        = jfs_ff;
            ks_in        = kfs_ff;
            slot_in      = kfslot_ff;
            n_in         = 2'd0;
         end
         if (c_last_pos) begin
            col_in = '0;
            jf_in  = '0;
            jfs_in = '0;
            if (r_last_pos) begin
               row_in    = '0;
               kfs_in    = '0;
               kfslot_in = '0;
            end else begin
               row_in = row_ff + HW'(1);
               if ((kfs_ff + R_PM1) < (row_e + EH'(1))) begin
                  kfs_in    = kfs_ff + R_STEP;
                  kfslot_in = (kfslot_ff == SLOT_LAST) ? '0 : kfslot_ff + SLW'(1);
               end
            end
         end else begin
            col_in = col_ff + WW'(1);
            if ((jfs_ff + C_PM1) < (col_e + EW'(1))) begin
               jf_in  = jf_ff + JW'(1);
               jfs_in = jfs_ff + C_STEP;
            end
         end
      end

      // Restart the frame on a register write
      if (restart) begin
         col_in    = '0;
         jf_in     = '0;
         jfs_in    = '0;
         row_in    = '0;
         kfs_in    = '0;
         kfslot_in = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         jf_ff        <= '0;
         jfs_ff       <= '0;
         row_ff       <= '0;
         kfs_ff       <= '0;
         kfslot_ff    <= '0;
         cur_valid_ff <= 1'b0;
         n_ff         <= 2'd0;
      end else begin
         col_ff       <= col_in;
         jf_ff        <= jf_in;
         jfs_ff       <= jfs_in;
         row_ff       <= row_in;
         kfs_ff       <= kfs_in;
         kfslot_ff    <= kfslot_in;
         cur_valid_ff <= cur_valid_in;
         n_ff         <= n_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      cr_ff     <= cr_in;
      cc_ff     <= cc_in;
      r_last_ff <= r_last_in;
      c_last_ff <= c_last_in;
      multi_ff  <= multi_in;
      jf_c_ff   <= jf_c_in;
      jfs_c_ff  <= jfs_c_in;
      j_ff      <= j_in;
      js_ff     <= js_in;
      ks_ff     <= ks_in;
      slot_ff   <= slot_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mp2d_rmw.sv -----
// Partial-max memory with read-modify-write stage, write forwarding and result register.
// Depends on mp2d_pkg; fed by mp2d_seq.
`default_nettype none

module mp2d_rmw #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                op_valid,
   input  wire logic [AW-1:0]                       op_addr,
   input  wire logic signed [mp2d_pkg::PIXEL_W-1:0] op_pixel,
   input  wire mp2d_pkg::op_flags_type              op_flags,
   output logic                                     issue_ok,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [mp2d_pkg::PIXEL_W-1:0]      rsp_pooled_value,
   output logic                                     rsp_end_of_row,
   output logic                                     rsp_end_of_frame,
   output logic                                     rsp_end_of_run
);

   localparam int PW = mp2d_pkg::PIXEL_W;

   logic signed [PW-1:0] partial_max_ff [DEPTH];
   logic signed [PW-1:0] rdata_ff;

   // Modify stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [AW-1:0]          s1_addr_ff;
   logic signed [PW-1:0]   s1_pixel_ff;
   mp2d_pkg::op_flags_type s1_flags_ff;

   // Last write, for a read that raced it
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]        fwd_addr_ff;
   logic signed [PW-1:0] fwd_data_ff;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [PW-1:0] rsp_value_ff;
   logic                 rsp_eor_ff, rsp_eof_ff, rsp_eorun_ff;

   logic                 out_free, s1_go, op_fire;
   logic signed [PW-1:0] old_max, new_max;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!s1_flags_ff.emit || out_free);
   assign issue_ok = !s1_valid_ff || s1_go;
   assign op_fire  = op_valid && issue_ok;

   // Merge the pixel into the window maximum
   assign old_max = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rdata_ff;
   assign new_max = (s1_flags_ff.first || (s1_pixel_ff > old_max)) ? s1_pixel_ff : old_max;

   // Memory read port
   always_ff @(posedge clock) begin
      if (op_fire) begin
         rdata_ff <= partial_max_ff[op_addr];
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (s1_go) begin
         partial_max_ff[s1_addr_ff] <= new_max;
      end
   end

   always_comb begin
      s1_valid_in = issue_ok ? op_valid : s1_valid_ff;
      fwd_valid_in = fwd_valid_ff || s1_go;
      if (s1_go && s1_flags_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      if (op_fire) begin
         s1_addr_ff  <= op_addr;
         s1_pixel_ff <= op_pixel;
         s1_flags_ff <= op_flags;
      end
      if (s1_go) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_max;
      end
      if (s1_go && s1_flags_ff.emit) begin
         rsp_value_ff <= new_max;
         rsp_eor_ff   <= s1_flags_ff.end_of_row;
         rsp_eof_ff   <= s1_flags_ff.end_of_frame;
         rsp_eorun_ff <= s1_flags_ff.end_of_run;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_end_of_run   = rsp_eorun_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/max_pool_2d_stream.sv -----
// Result path: mp2d_seq pixel register, mp2d_rmw modify stage, then the result register.
// Input flow: a pixel is held until one operation per covering window has gone through the
//   single read-modify-write port of the partial-max memory; a stalled result can hold it too.
// Reset: clears position counters and valid bits, sets width to 256 (bounded by MAX_WIDTH)
//   and height to 256; the partial-max memory is not cleared, no clearing pass.
`default_nettype none

module max_pool_2d_stream #(
   parameter int POOL_SIZE = 2,
   parameter int STRIDE    = 2,
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [mp2d_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mp2d_pkg::DIM_W-1:0]            csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [mp2d_pkg::PIXEL_W-1:0]   req_pixel,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [mp2d_pkg::PIXEL_W-1:0]        rsp_pooled_value,
   output logic                                       rsp_end_of_row,
   output logic                                       rsp_end_of_frame,
   output logic                                       rsp_end_of_run
);

   localparam int HW    = mp2d_pkg::DIM_W;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMPW  = (WW > HW) ? WW : HW;
   localparam int COLS  = (MAX_WIDTH - 1) / STRIDE + 1;
   localparam int JW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RS    = (POOL_SIZE + STRIDE - 1) / STRIDE;
   localparam int SLW   = (RS > 1) ? $clog2(RS) : 1;
   localparam int DEPTH = RS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RESET_W = (mp2d_pkg::RESET_DIM > MAX_WIDTH) ? MAX_WIDTH
                                                               : mp2d_pkg::RESET_DIM;

   logic [WW-1:0]   img_w_ff, img_w_in;
   logic [HW-1:0]   img_h_ff, img_h_in;
   logic [CMPW-1:0] wdata_ext;
   logic [WW-1:0]   w_clamped;
   logic [HW-1:0]   h_clamped;

   logic                          op_valid, issue_ok;
   logic [AW-1:0]                 op_addr;
   logic signed [mp2d_pkg::PIXEL_W-1:0] op_pixel;
   mp2d_pkg::op_flags_type        op_flags;

   // Bound the written dimensions
   assign wdata_ext = CMPW'(csr_wdata);
   assign w_clamped = (wdata_ext == '0) ? WW'(1) :
                      (wdata_ext > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wdata_ext);
   assign h_clamped = (csr_wdata == '0) ? HW'(1) :
                      (csr_wdata > HW'(mp2d_pkg::HEIGHT_LIMIT)) ?
                      HW'(mp2d_pkg::HEIGHT_LIMIT) : csr_wdata;

   // Decode register writes
   always_comb begin
      img_w_in = img_w_ff;
      img_h_in = img_h_ff;
      if (csr_wr_en) begin
         case (mp2d_pkg::csr_index_type'(csr_index))
            mp2d_pkg::CSR_IMAGE_WIDTH: begin
               img_w_in = w_clamped;
            end
            mp2d_pkg::CSR_IMAGE_HEIGHT: begin
               img_h_in = h_clamped;
            end
            default: begin
               img_w_in = img_w_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= WW'(RESET_W);
         img_h_ff <= HW'(mp2d_pkg::RESET_DIM);
      end else begin
         img_w_ff <= img_w_in;
         img_h_ff <= img_h_in;
      end
   end

   mp2d_seq #(
      .POOL_SIZE (POOL_SIZE),
      .STRIDE    (STRIDE),
      .COLS      (COLS),
      .RS        (RS),
      .WW        (WW),
      .JW        (JW),
      .SLW       (SLW),
      .AW        (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_wr_en),
      .img_w     (img_w_ff),
      .img_h     (img_h_ff),
      .req_valid (req_valid),
      .req_pixel (req_pixel),
      .req_stall (req_stall),
      .issue_ok  (issue_ok),
      .op_valid  (op_valid),
      .op_addr   (op_addr),
      .op_pixel  (op_pixel),
      .op_flags  (op_flags)
   );

   mp2d_rmw #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_rmw (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (op_valid),
      .op_addr          (op_addr),
      .op_pixel         (op_pixel),
      .op_flags         (op_flags),
      .issue_ok         (issue_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_end_of_run   (rsp_end_of_run)
   );

`ifndef SYNTHESIS
   // The last window of a frame also closes its window row
   a_frame_closes_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_end_of_frame || rsp_end_of_row))
      else $error("end_of_frame without end_of_row");

   // An operation refused by the memory stage is held unchanged
   a_refused_op_holds: assert property (@(posedge clock) disable iff (reset)
      (op_valid && !issue_ok) |=> (op_valid && $stable(op_addr) && $stable(op_flags)))
      else $error("refused memory operation changed");

   // Input is stalled only while a pixel is still being worked on
   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> op_valid)
      else $error("input stalled with no pixel in work");
`endif

endmodule

`default_nettype wire

// ----- sim/max_pool_2d_stream_check.sv -----
// Checker for max_pool_2d_stream: watches the configuration port and both channels,
// predicts the pooled results of every accepted pixel and compares them in order.
// Depends on mp2d_pkg for widths, register indexes and reset dimensions.
`timescale 1ns / 1ps

module max_pool_2d_stream_check #(
   parameter int POOL_SIZE = 2,
   parameter int STRIDE    = 2,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mp2d_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mp2d_pkg::DIM_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [mp2d_pkg::PIXEL_W-1:0] req_pixel,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [mp2d_pkg::PIXEL_W-1:0] rsp_pooled_value,
   input  logic                                rsp_end_of_row,
   input  logic                                rsp_end_of_frame,
   input  logic                                rsp_end_of_run,
   output int                                  errors,
   output int                                  pending,
   output int                                  checked
);
   import mp2d_pkg::*;

   localparam int ROW_SLOTS   = (POOL_SIZE + STRIDE - 1) / STRIDE;
   localparam int MAX_REPORTS = 2;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] value;
      logic                      end_of_row;
      logic                      end_of_frame;
      logic                      end_of_run;
   } window_result_type;

   // Shadow of the block's configuration and position
   logic [DIM_W-1:0]          width_reg;
   logic [DIM_W-1:0]          height_reg;
   int unsigned               pixel_col;
   int unsigned               pixel_row;
   logic signed [PIXEL_W-1:0] window_max [ROW_SLOTS*MAX_WIDTH];

   window_result_type expected_windows [$];

   function automatic int unsigned bound_dim(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // Index of the first window along one axis that still covers position pos
   function automatic int unsigned first_window(input int unsigned pos);
      if (pos + 1 <= POOL_SIZE) return 0;
      return (pos + 1 - POOL_SIZE + STRIDE - 1) / STRIDE;
   endfunction

   // Fold one pixel into every window covering it; queue the windows it completes
   task automatic pool_pixel(input logic signed [PIXEL_W-1:0] px);
      int unsigned               w, h, r, c, k, j, r0, c0, rend, cend, idx;
      int                        n;
      logic signed [PIXEL_W-1:0] m;
      logic                      row_done;
      window_result_type         found [MAX_REPORTS];
      w = bound_dim(width_reg, MAX_WIDTH);
      h = bound_dim(height_reg, HEIGHT_LIMIT);
      r = pixel_row;
      c = pixel_col;
      n = 0;
      if (r >= h || c >= w) begin
         r = 0;
         c = 0;
      end
      for (k = first_window(r); k <= r / STRIDE; k++) begin
         r0   = k * STRIDE;
         rend = r0 + POOL_SIZE - 1;
         if (rend > h - 1) rend = h - 1;
         row_done = (rend == r);
         for (j = first_window(c); j <= c / STRIDE; j++) begin
            c0  = j * STRIDE;
            idx = (k % ROW_SLOTS) * MAX_WIDTH + j;
            if (idx >= ROW_SLOTS * MAX_WIDTH) continue;
            if (r == r0 && c == c0) begin
               m = px;
            end else begin
               m = window_max[idx];
               if (px > m) m = px;
            end
            window_max[idx] = m;
            cend = c0 + POOL_SIZE - 1;
            if (cend > w - 1) cend = w - 1;
            if (row_done && cend == c && n < MAX_REPORTS) begin
               found[n].value        = m;
               found[n].end_of_row   = (c0 + STRIDE >= w);
               found[n].end_of_frame = found[n].end_of_row && (r0 + STRIDE >= h);
               found[n].end_of_run   = 1'b0;
               n++;
            end
         end
      end
      if (n > 0) found[n-1].end_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_windows.push_back(found[i]);

      // Advance the raster position
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      pixel_col = c;
      pixel_row = r;
   endtask

   always @(posedge clock) begin
      window_result_type exp_item;
      if (reset) begin
         width_reg  = DIM_W'(RESET_DIM);
         height_reg = DIM_W'(RESET_DIM);
         pixel_col  = 0;
         pixel_row  = 0;
         expected_windows.delete();
      end else begin
         // Compare the result item against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               $error("pooled_value: no result expected, got %0d", rsp_pooled_value);
               errors++;
            end else begin
               exp_item = expected_windows.pop_front();
               checked++;
               if (rsp_pooled_value !== exp_item.value) begin
                  $error("pooled_value: expected %0d, got %0d",
                         exp_item.value, rsp_pooled_value);
                  errors++;
               end
               if (rsp_end_of_row !== exp_item.end_of_row) begin
                  $error("end_of_row: expected %0b, got %0b",
                         exp_item.end_of_row, rsp_end_of_row);
                  errors++;
               end
               if (rsp_end_of_frame !== exp_item.end_of_frame) begin
                  $error("end_of_frame: expected %0b, got %0b",
                         exp_item.end_of_frame, rsp_end_of_frame);
                  errors++;
               end
               if (rsp_end_of_run !== exp_item.end_of_run) begin
                  $error("end_of_run: expected %0b, got %0b",
                         exp_item.end_of_run, rsp_end_of_run);
                  errors++;
               end
            end
         end

         // A register write also restarts the frame
         if (csr_wr_en) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
            pixel_col = 0;
            pixel_row = 0;
         end

         if (req_valid && !req_stall) pool_pixel(req_pixel);
      end
      pending = expected_windows.size();
   end

endmodule

// ----- sim/max_pool_2d_stream_tb.sv -----
// Testbench top for max_pool_2d_stream: clock, reset, pixel and stall stimulus,
// geometry writes, watchdog and verdict. Depends on mp2d_pkg, the block and
// max_pool_2d_stream_check, which predicts and compares the results.
`timescale 1ns / 1ps

module max_pool_2d_stream_tb;
   import mp2d_pkg::*;

   localparam int RANDOM_ITEMS   = 350;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_BURST      = 200;

   localparam logic signed [PIXEL_W-1:0] FRAME_3X3 [9] = '{
      16'sh8000, 16'sh8000, 16'sh7FFF,
      16'sh8000, 16'sh8000, 16'shFFFF,
      16'sh0000, 16'sh0001, 16'shFFFE
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [DIM_W-1:0]          csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [PIXEL_W-1:0] req_pixel;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [PIXEL_W-1:0] rsp_pooled_value;
   logic                      rsp_end_of_row;
   logic                      rsp_end_of_frame;
   logic                      rsp_end_of_run;

   int errors;
   int pending;
   int checked;

   // Stimulus knobs, changed only between phases
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   bit          quiet     = 1'b0;
   int unsigned pixels_sent = 0;
   int unsigned phases      = 0;
   int unsigned cur_width   = RESET_DIM;
   int unsigned cur_height  = RESET_DIM;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;

   always #4 clock = ~clock;

   max_pool_2d_stream DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame),
      .rsp_end_of_run  (rsp_end_of_run)
   );

   max_pool_2d_stream_check checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_end_of_row  (rsp_end_of_row),
      .rsp_end_of_frame(rsp_end_of_frame),
      .rsp_end_of_run  (rsp_end_of_run),
      .errors          (errors),
      .pending         (pending),
      .checked         (checked)
   );

   // Receiver stalls in bursts of random length, each started with a chance of stall_pct percent
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("max_pool_2d_stream_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // Mix of full-range values, values near zero, the extremes and values close to them
   function automatic logic signed [PIXEL_W-1:0] pick_pixel();
      logic signed [PIXEL_W-1:0] px;
      case ($urandom_range(0, 9))
         0:       px = 16'sh7FFF;
         1:       px = 16'sh8000;
         2:       px = PIXEL_W'($urandom_range(0, 7) - 4);
         3:       px = 16'sh7FFF - PIXEL_W'($urandom_range(0, 3));
         4:       px = 16'sh8000 + PIXEL_W'($urandom_range(0, 3));
         default: px = PIXEL_W'($urandom);
      endcase
      return px;
   endfunction

   function automatic int unsigned pick_dim(input int unsigned typical, input int unsigned hi);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(typical + 1, hi);
         default: return $urandom_range(1, typical);
      endcase
   endfunction

   // Offer one pixel, maybe after a short gap, and hold it until accepted
   task automatic send_pixel(input logic signed [PIXEL_W-1:0] px);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         req_pixel <= PIXEL_W'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   task automatic send_random(input int unsigned n);
      repeat (n) send_pixel(pick_pixel());
      end_burst();
   endtask

   // Wait until every predicted result has arrived and the pipeline has drained
   task automatic settle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input bit wr_width, input bit wr_height);
      settle();
      csr_wr_en <= 1'b1;
      if (wr_width) begin
         csr_index <= CSR_IMAGE_WIDTH;
         csr_wdata <= DIM_W'(w);
         cur_width = w;
         @(posedge clock);
      end
      if (wr_height) begin
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_wdata <= DIM_W'(h);
         cur_height = h;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      phases++;
   endtask

   initial begin
      int unsigned random_items;
      int unsigned w, h, area, n, mode;
      req_valid    = 1'b0;
      req_pixel    = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      reset        = 1'b1;
      random_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry of 256 x 256: cross into the second row to close windows
      gap_pct   = 15;
      stall_pct = 15;
      send_random(262);

      // Odd 3 x 3 frame: partial windows at the right and bottom edges,
      // one window of minimum values only, then a wrap into the next frame
      set_geometry(3, 3, 1'b1, 1'b1);
      foreach (FRAME_3X3[i]) send_pixel(FRAME_3X3[i]);
      send_pixel(16'sh7FFF);
      send_pixel(16'sh8000);
      end_burst();

      // Zero dimensions count as one: every pixel is a frame of its own
      set_geometry(0, 0, 1'b1, 1'b1);
      send_pixel(16'sh7FFF);
      send_pixel(16'sh8000);
      send_pixel(16'sh0000);
      end_burst();

      // One-row frame, height and width written in separate writes
      set_geometry(0, 1, 1'b0, 1'b1);
      set_geometry(2, 1, 1'b1, 1'b0);
      send_pixel(16'sh8000);
      send_pixel(16'sh8001);
      send_pixel(16'sh7FFE);
      send_pixel(16'sh7FFF);
      send_pixel(16'shFFFF);
      end_burst();

      // Oversized registers saturate to the width and height bounds
      set_geometry(2047, 1, 1'b1, 1'b1);
      send_random(40);
      set_geometry(1, 2047, 1'b1, 1'b1);
      send_random(40);

      // Random geometries, mostly small, often cut off mid-frame
      while (random_items < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 5);
         w    = (mode == 1) ? cur_width : pick_dim(9, 40);
         h    = (mode == 0) ? cur_height : pick_dim(6, 12);
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 40;
         endcase
         set_geometry(w, h, mode != 1, mode != 0);
         area = eff_dim(cur_width, 1024) * eff_dim(cur_height, HEIGHT_LIMIT);
         n    = $urandom_range(1, (2 * area + 3 < MAX_BURST) ? 2 * area + 3 : MAX_BURST);
         send_random(n);
         random_items += n;
      end

      // Closing stretch at full rate on both sides
      quiet = 1'b1;
      set_geometry(5, 4, 1'b1, 1'b1);
      send_random(50);

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pixels in %0d geometry phases, %0d pooled results compared.",
               pixels_sent, phases, checked);
      if (errors == 0) begin
         $display("max_pool_2d_stream_tb OK");
      end else begin
         $display("max_pool_2d_stream_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- max_pool_2d_stream.f -----
hw/rtl/mp2d_pkg.sv
hw/rtl/mp2d_seq.sv
hw/rtl/mp2d_rmw.sv
hw/rtl/max_pool_2d_stream.sv
sim/max_pool_2d_stream_check.sv
sim/max_pool_2d_stream_tb.sv
